>>> src/ptg_pkg.sv
`timescale 1ns / 1ps

package ptg_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DUR_W       = 16;
   localparam int ACT_W       = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DUR_W-1:0] OFFSET_RESET = 16'd72;

   localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SCHED  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_STAGE  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_COMMIT = 2'd3;

   localparam logic REG_DURATION_OFFSET = 1'b0;

   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] dur;
   } seg_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

>>> src/ptg_cell.sv
`timescale 1ns / 1ps

module ptg_cell (
   input  logic                 clock,
   input  ptg_pkg::cell_ctl_type ctl,
   input  ptg_pkg::seg_type     nbr_seg,
   input  ptg_pkg::seg_type     new_seg,
   output ptg_pkg::seg_type     seg
);
   import ptg_pkg::*;

   seg_type seg_ff;
   seg_type seg_in;

   // load wins over shift: on a pop the new entry lands one slot nearer the head
   always_comb begin
      seg_in = seg_ff;
      if (ctl.load) begin
         seg_in = new_seg;
      end else if (ctl.shift) begin
         seg_in = nbr_seg;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

>>> src/ptg_csr.sv
`timescale 1ns / 1ps

module ptg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [ptg_pkg::DUR_W-1:0]         duration_offset
);
   import ptg_pkg::*;

   logic [DUR_W-1:0] offset_ff;
   logic [DUR_W-1:0] offset_in;
   logic             reg_idx;
   logic             wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      offset_in = offset_ff;
      if (wr_en && (reg_idx == REG_DURATION_OFFSET)) begin
         offset_in = csr_pwdata[DUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_DURATION_OFFSET) begin
         csr_prdata = CSR_DATA_W'(offset_ff);
      end
   end

   assign csr_pready      = 1'b1;
   assign duration_offset = offset_ff;

endmodule

>>> src/fifo_pulse_train_generator_top.sv
`timescale 1ns / 1ps

// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; a new beat is taken while the result
// register is empty or being drained, so the row of queue cells never stalls it.
// Reset: clears queue counts, timer, running flag and pin level; offset reloads 72.
// Queue cell contents are not cleared; no clearing pass follows reset.
module fifo_pulse_train_generator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ptg_pkg::ACT_W-1:0]         req_action,
   input  logic                              req_level_bit,
   input  logic [ptg_pkg::DUR_W-1:0]         req_duration,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pin_level,
   output logic                              rsp_running,
   output logic [ptg_pkg::COUNT_OUT_W-1:0]   rsp_queue_count,
   output logic                              rsp_dropped,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ptg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import ptg_pkg::*;

   logic [DUR_W-1:0] duration_offset;

   logic [CNT_W-1:0] vis_ff, vis_in, vis_mid;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [DUR_W-1:0] tick_ff, tick_in;
   logic [DUR_W-1:0] reload_ff, reload_in;
   logic             active_ff, active_in;
   logic             level_ff, level_in;

   logic             rsp_valid_ff;
   logic             rsp_level_ff;
   logic             rsp_running_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_dropped_ff;

   logic             accept;
   logic             full;
   logic             push;
   logic             pop_req;
   logic             pop_do;
   logic             dropped;
   logic             store_new;
   logic [DUR_W-1:0] adj_dur;
   logic [CNT_W-1:0] wr_pos;
   seg_type          new_seg;
   seg_type          head_seg;

   seg_type          seg_q   [QUEUE_DEPTH];
   seg_type          nbr_q   [QUEUE_DEPTH];
   cell_ctl_type     cell_ctl[QUEUE_DEPTH];

   ptg_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .duration_offset (duration_offset)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (total_ff == CNT_W'(QUEUE_DEPTH));

   assign adj_dur       = (req_duration > duration_offset) ? (req_duration - duration_offset)
                                                           : '0;
   assign new_seg.level = req_level_bit;
   assign new_seg.dur   = adj_dur;

   // with nothing stored, the segment pushed in this beat is the one popped
   assign head_seg = (total_ff == '0) ? new_seg : seg_q[0];

   always_comb begin
      push     = 1'b0;
      dropped  = 1'b0;
      pop_req  = 1'b0;
      vis_mid  = vis_ff;
      total_in = total_ff;
      tick_in  = tick_ff;
      unique case (req_action)
         ACT_TICK: begin
            if (active_ff) begin
               if (tick_ff == reload_ff) begin
                  pop_req = 1'b1;
               end else begin
                  tick_in = tick_ff + DUR_W'(1);
               end
            end
         end
         ACT_SCHED: begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               push     = 1'b1;
               vis_mid  = vis_ff + CNT_W'(1);
               total_in = total_ff + CNT_W'(1);
               pop_req  = !active_ff;
            end
         end
         ACT_STAGE: begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               push     = 1'b1;
               total_in = total_ff + CNT_W'(1);
            end
         end
         ACT_COMMIT: begin
            vis_mid = total_ff;
            pop_req = !active_ff;
         end
         default: begin
         end
      endcase

      vis_in    = vis_mid;
      pop_do    = 1'b0;
      level_in  = level_ff;
      active_in = active_ff;
      reload_in = reload_ff;
      if (pop_req) begin
         if (vis_mid == '0) begin
            level_in  = 1'b0;
            active_in = 1'b0;
         end else begin
            pop_do   = 1'b1;
            vis_in   = vis_mid - CNT_W'(1);
            total_in = total_in - CNT_W'(1);
            level_in = head_seg.level;
            // level low with zero length ends the train
            if (!head_seg.level && (head_seg.dur == '0)) begin
               active_in = 1'b0;
            end else begin
               active_in = 1'b1;
               reload_in = head_seg.dur;
               tick_in   = '0;
            end
         end
      end
   end

   assign wr_pos    = pop_do ? (total_ff - CNT_W'(1)) : total_ff;
   assign store_new = push && !(pop_do && (total_ff == '0));

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nbr_q[i] = seg_q[i];
      end else begin : g_body
         assign nbr_q[i] = seg_q[i+1];
      end

      assign cell_ctl[i].load  = accept && store_new && (wr_pos == CNT_W'(i));
      assign cell_ctl[i].shift = accept && pop_do;

      ptg_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .nbr_seg (nbr_q[i]),
         .new_seg (new_seg),
         .seg     (seg_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff    <= '0;
         total_ff  <= '0;
         tick_ff   <= '0;
         reload_ff <= '0;
         active_ff <= 1'b0;
         level_ff  <= 1'b0;
      end else if (accept) begin
         vis_ff    <= vis_in;
         total_ff  <= total_in;
         tick_ff   <= tick_in;
         reload_ff <= reload_in;
         active_ff <= active_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_level_ff   <= level_in;
         rsp_running_ff <= active_in;
         rsp_count_ff   <= vis_in;
         rsp_dropped_ff <= dropped;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pin_level   = rsp_level_ff;
   assign rsp_running     = rsp_running_ff;
   assign rsp_queue_count = COUNT_OUT_W'(rsp_count_ff);
   assign rsp_dropped     = rsp_dropped_ff;

`ifndef ASSERT_OFF
   a_vis_le_total: assert property (@(posedge clock) disable iff (reset)
      vis_ff <= total_ff)
      else $error("visible count exceeds stored count");

   a_total_le_depth: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("stored count exceeds queue depth");

   a_tick_le_reload: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (tick_ff <= reload_ff))
      else $error("tick counter ran past reload value");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (accept && dropped) |=> (total_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("beat dropped while queue had room");

   a_idle_timer_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !active_ff && (req_action == ACT_TICK)) |=> $stable(tick_ff))
      else $error("timer moved while stopped");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import ptg_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] OFFSET_ADDR = CSR_ADDR_W'(4 * int'(REG_DURATION_OFFSET));

   typedef struct packed {
      logic                   pin_level;
      logic                   running;
      logic [COUNT_OUT_W-1:0] queue_count;
      logic                   dropped;
   } pin_status_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [ACT_W-1:0]       req_action;
   logic                   req_level_bit;
   logic [DUR_W-1:0]       req_duration;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_pin_level;
   logic                   rsp_running;
   logic [COUNT_OUT_W-1:0] rsp_queue_count;
   logic                   rsp_dropped;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // generator shadow state
   seg_type          seg_mem [QUEUE_DEPTH];
   int               wr_idx;
   int               rd_idx;
   int               shown_cnt;
   int               staged_cnt;
   logic [DUR_W-1:0] tick_cnt;
   logic [DUR_W-1:0] hold_ticks;
   logic             gen_on;
   logic             pin_lvl;
   logic [DUR_W-1:0] offset_q;

   pin_status_type pending_status[$];
   int             err_cnt;
   int             beats_sent;
   int             gap_pct;
   int             stall_pct;
   int             hold_left;

   fifo_pulse_train_generator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_level_bit   (req_level_bit),
      .req_duration    (req_duration),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pin_level   (rsp_pin_level),
      .rsp_running     (rsp_running),
      .rsp_queue_count (rsp_queue_count),
      .rsp_dropped     (rsp_dropped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("fifo_pulse_train_generator_top: mismatch");
      $finish;
   end

   function automatic void take_next_segment();
      seg_type seg;
      if (shown_cnt == 0) begin
         pin_lvl = 1'b0;
         gen_on  = 1'b0;
         return;
      end
      seg       = seg_mem[rd_idx];
      rd_idx    = (rd_idx + 1) % QUEUE_DEPTH;
      shown_cnt = shown_cnt - 1;
      pin_lvl   = seg.level;
      // level low with nothing left to hold ends the train
      if (!seg.level && seg.dur == '0) begin
         gen_on = 1'b0;
         return;
      end
      gen_on     = 1'b1;
      hold_ticks = seg.dur;
      tick_cnt   = '0;
   endfunction

   function automatic void store_segment(logic lvl, logic [DUR_W-1:0] dur);
      seg_mem[wr_idx].level = lvl;
      seg_mem[wr_idx].dur   = (dur > offset_q) ? dur - offset_q : '0;
      wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
   endfunction

   function automatic pin_status_type next_pin_status(logic [ACT_W-1:0] act, logic lvl,
                                                      logic [DUR_W-1:0] dur);
      pin_status_type st;
      logic           full;
      st.dropped = 1'b0;
      full = (shown_cnt + staged_cnt) >= QUEUE_DEPTH;
      case (act)
         ACT_TICK: begin
            if (gen_on) begin
               if (tick_cnt == hold_ticks) take_next_segment();
               else tick_cnt = tick_cnt + 1'b1;
            end
         end
         ACT_SCHED: begin
            if (full) begin
               st.dropped = 1'b1;
            end else begin
               store_segment(lvl, dur);
               shown_cnt = shown_cnt + 1;
               if (!gen_on) take_next_segment();
            end
         end
         ACT_STAGE: begin
            if (full) begin
               st.dropped = 1'b1;
            end else begin
               store_segment(lvl, dur);
               staged_cnt = staged_cnt + 1;
            end
         end
         default: begin
            shown_cnt  = shown_cnt + staged_cnt;
            staged_cnt = 0;
            if (!gen_on) take_next_segment();
         end
      endcase
      st.pin_level   = pin_lvl;
      st.running     = gen_on;
      st.queue_count = COUNT_OUT_W'(shown_cnt);
      return st;
   endfunction

   // durations mostly land a few ticks past the offset so segments play quickly
   function automatic logic [DUR_W-1:0] pick_duration();
      int d;
      if (offset_q == '1) return DUR_W'($urandom());
      if ($urandom_range(15) == 0) return DUR_W'($urandom_range(int'(offset_q), 0));
      d = int'(offset_q) + $urandom_range(6);
      if (d > 65535) d = 65535;
      return DUR_W'(d);
   endfunction

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      pin_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("result beat with no request pending");
            err_cnt++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_pin_level !== want.pin_level) begin
               $error("pin_level: expected %0d, actual %0d", want.pin_level, rsp_pin_level);
               err_cnt++;
            end
            if (rsp_running !== want.running) begin
               $error("running: expected %0d, actual %0d", want.running, rsp_running);
               err_cnt++;
            end
            if (rsp_queue_count !== want.queue_count) begin
               $error("queue_count: expected %0d, actual %0d", want.queue_count,
                      rsp_queue_count);
               err_cnt++;
            end
            if (rsp_dropped !== want.dropped) begin
               $error("dropped: expected %0d, actual %0d", want.dropped, rsp_dropped);
               err_cnt++;
            end
         end
      end
   end

   task automatic send_beat(input logic [ACT_W-1:0] act, input logic lvl,
                            input logic [DUR_W-1:0] dur);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = act;
      req_level_bit = lvl;
      req_duration  = dur;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(next_pin_status(act, lvl, dur));
      beats_sent++;
   endtask

   task automatic req_quiet();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic set_traffic(input int sender_idle, input int receiver_stall);
      gap_pct   = sender_idle;
      stall_pct = receiver_stall;
   endtask

   task automatic write_offset(input logic [DUR_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      req_quiet();
      wait_drained();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = OFFSET_ADDR;
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      offset_q = value;
      // read back through a fresh setup phase
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (rd[DUR_W-1:0] !== value) begin
         $error("duration_offset: expected %0d, actual %0d", value, rd[DUR_W-1:0]);
         err_cnt++;
      end
   endtask

   task automatic send_random(input int count);
      int stop_at;
      int kind;
      int n;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            repeat ($urandom_range(1, 4))
               send_beat(ACT_SCHED, 1'($urandom_range(1)), pick_duration());
         end else if (kind < 75) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(7) == 0)
                  send_beat(ACT_SCHED, 1'($urandom_range(1)), pick_duration());
               else
                  send_beat(ACT_STAGE, 1'($urandom_range(1)), pick_duration());
            end
            // leave some bulks open so later schedules land behind them
            if ($urandom_range(9) != 0)
               send_beat(ACT_COMMIT, 1'($urandom_range(1)), DUR_W'($urandom()));
         end else begin
            send_beat(ACT_W'($urandom_range(3)), 1'($urandom_range(1)), pick_duration());
         end
         repeat ($urandom_range(0, 10))
            send_beat(ACT_TICK, 1'($urandom_range(1)), DUR_W'($urandom()));
      end
   endtask

   task automatic test_directed();
      send_beat(ACT_TICK, 1'b1, 16'hFFFF);
      send_beat(ACT_COMMIT, 1'b0, 16'h0000);
      send_beat(ACT_SCHED, 1'b1, 16'd0);
      send_beat(ACT_TICK, 1'b0, 16'd0);
      send_beat(ACT_SCHED, 1'b0, 16'd0);
      send_beat(ACT_SCHED, 1'b1, 16'd75);
      send_beat(ACT_SCHED, 1'b0, 16'd74);
      send_beat(ACT_STAGE, 1'b1, 16'hFFFF);
      send_beat(ACT_COMMIT, 1'b1, 16'hFFFF);
      repeat (4) send_beat(ACT_TICK, 1'b0, 16'h5555);
      // schedule lands behind an open bulk
      send_beat(ACT_STAGE, 1'b1, 16'd73);
      send_beat(ACT_SCHED, 1'b0, 16'd72);
      send_beat(ACT_TICK, 1'b1, 16'hAAAA);
      send_beat(ACT_COMMIT, 1'b0, 16'd0);
      repeat (8) send_beat(ACT_TICK, 1'b1, 16'h8000);
      req_quiet();
   endtask

   task automatic test_long_segment();
      write_offset(16'd0);
      send_beat(ACT_SCHED, 1'b1, 16'd200);
      send_beat(ACT_SCHED, 1'b0, 16'h0000);
      repeat (203) send_beat(ACT_TICK, 1'b0, 16'd0);
      req_quiet();
   endtask

   task automatic test_queue_full();
      write_offset(OFFSET_RESET);
      repeat (QUEUE_DEPTH + 2) send_beat(ACT_STAGE, 1'b1, 16'd72 + 16'($urandom_range(4)));
      send_beat(ACT_SCHED, 1'b1, 16'd80);
      send_beat(ACT_COMMIT, 1'b0, 16'd0);
      send_beat(ACT_SCHED, 1'b0, 16'd90);
      repeat (130) send_beat(ACT_TICK, 1'b0, 16'd0);
      req_quiet();
   endtask

   task automatic test_random_phases();
      write_offset(16'd72);
      set_traffic(0, 0);
      send_random(130);
      write_offset(16'd0);
      set_traffic(87, 0);
      send_random(130);
      write_offset(16'hFFFF);
      set_traffic(0, 87);
      send_random(130);
      write_offset(16'd3);
      set_traffic(34, 34);
      send_random(130);
      write_offset(16'($urandom_range(1, 10)));
      set_traffic(0, 0);
      send_random(130);
      req_quiet();
   endtask

   task automatic test_backpressure();
      write_offset(16'd2);
      set_traffic(0, 0);
      hold_left = 400;
      send_random(80);
      req_quiet();
   endtask

   task automatic test_drain_pause();
      set_traffic(34, 34);
      send_random(40);
      req_quiet();
      wait_drained();
      send_random(40);
      req_quiet();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_TICK;
      req_level_bit = 1'b0;
      req_duration  = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      wr_idx        = 0;
      rd_idx        = 0;
      shown_cnt     = 0;
      staged_cnt    = 0;
      tick_cnt      = '0;
      hold_ticks    = '0;
      gen_on        = 1'b0;
      pin_lvl       = 1'b0;
      offset_q      = OFFSET_RESET;
      err_cnt       = 0;
      beats_sent    = 0;
      gap_pct       = 0;
      stall_pct     = 0;
      hold_left     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_long_segment();
      test_queue_full();
      test_random_phases();
      test_backpressure();
      test_drain_pause();

      wait_drained();
      repeat (10) @(posedge clock);
      if (err_cnt == 0 && pending_status.size() == 0) begin
         $display("fifo_pulse_train_generator_top: match");
      end else begin
         $display("fifo_pulse_train_generator_top: mismatch");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ptg_pkg.sv
src/ptg_cell.sv
src/ptg_csr.sv
src/fifo_pulse_train_generator_top.sv
tb/sv/tb.sv
